### sv/razct_pkg.sv
// Shared types, constants and arithmetic helpers for the range add and zero count tree.
// No dependencies; every other module of the block imports this package.
`default_nettype none

package razct_pkg;

    localparam int MAX_POSITIONS = 1024;
    localparam int POS_W         = 10;
    localparam int CNT_W         = 11;
    localparam int ADDR_W        = 11;
    localparam int NODE_SLOTS    = 2 * MAX_POSITIONS;
    localparam int CLR_W         = ADDR_W + 1;
    localparam int VAL_W         = 16;
    localparam int DELTA_W       = 8;
    localparam int STACK_DEPTH   = 10;
    localparam int SP_W          = 4;

    localparam logic [0:0] REQ_ADD   = 1'b0;
    localparam logic [0:0] REQ_QUERY = 1'b1;

    typedef struct packed {
        logic signed [VAL_W-1:0] mn;
        logic [CNT_W-1:0]        cnt;
        logic signed [VAL_W-1:0] pend;
    } t_node;

    typedef struct packed {
        logic  valid;
        t_node node;
    } t_word;

    typedef struct packed {
        logic accept;
        logic clr_step;
        logic ld_root;
        logic visit;
        logic ld_left;
        logic ld_right;
        logic push_l;
        logic push_r;
        logic push_n;
        logic ret_step;
    } t_cmd;

    typedef struct packed {
        logic noop;
        logic cls_none;
        logic cls_full;
        logic pend_zero;
        logic stack_empty;
        logic phase_right;
        logic clr_done;
    } t_status;

    function automatic logic signed [VAL_W-1:0] sat_add(
        input logic signed [VAL_W-1:0] a,
        input logic signed [VAL_W-1:0] b
    );
        logic signed [VAL_W:0] s;
        s = $signed({a[VAL_W-1], a}) + $signed({b[VAL_W-1], b});
        if (s > $signed({2'b00, {(VAL_W-1){1'b1}}})) begin
            return {1'b0, {(VAL_W-1){1'b1}}};
        end else if (s < $signed({2'b11, {(VAL_W-1){1'b0}}})) begin
            return {1'b1, {(VAL_W-1){1'b0}}};
        end
        return s[VAL_W-1:0];
    endfunction

    function automatic t_node apply_add(input t_node v, input logic signed [VAL_W-1:0] d);
        t_node r;
        r      = v;
        r.mn   = sat_add(v.mn, d);
        r.pend = sat_add(v.pend, d);
        return r;
    endfunction

endpackage

`default_nettype wire

### sv/range_add_zero_count_tree_top.sv
// A no-op item answers in the cycle after it is accepted; other items walk the tree
// through the node memory, with one visit for each node wholly inside or outside the
// range and, for each partly covered node, a visit, loads of both children, a push-down
// of any pending add and return steps. Items are taken one at a time; the next is taken
// after the result transaction completes. Reset and every register write start a
// clearing pass over node memory, during which no item is taken.
`default_nettype none

module range_add_zero_count_tree_top import razct_pkg::*; (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_valid,
    output logic                           o_ready,
    input  wire logic                      i_req_type,
    input  wire logic [POS_W-1:0]          i_range_first,
    input  wire logic [POS_W-1:0]          i_range_last,
    input  wire logic signed [DELTA_W-1:0] i_delta,
    output logic                           o_valid,
    input  wire logic                      i_ready,
    output logic [CNT_W-1:0]               o_zero_count,
    input  wire logic                      i_cfg_we,
    input  wire logic [CNT_W-1:0]          i_cfg_data
);

    t_cmd    cmd;
    t_status status;

    razct_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .i_cfg_we (i_cfg_we),
        .i_status (status),
        .o_cmd    (cmd)
    );

    razct_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_req_type    (i_req_type),
        .i_range_first (i_range_first),
        .i_range_last  (i_range_last),
        .i_delta       (i_delta),
        .i_cmd         (cmd),
        .o_status      (status),
        .o_zero_count  (o_zero_count)
    );

endmodule

`default_nettype wire

### sv/razct_ctrl.sv
// Sequencing state machine for the tree walk, clear pass and result handshake.
// Depends on razct_pkg for the command and status structs.
`default_nettype none

module razct_ctrl import razct_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_valid,
    output logic         o_ready,
    output logic         o_valid,
    input  wire logic    i_ready,
    input  wire logic    i_cfg_we,
    input  wire t_status i_status,
    output t_cmd         o_cmd
);

    typedef enum logic [10:0] {
        S_CLEAR = 11'b000_0000_0001,
        S_IDLE  = 11'b000_0000_0010,
        S_ROOT  = 11'b000_0000_0100,
        S_VISIT = 11'b000_0000_1000,
        S_RDL   = 11'b000_0001_0000,
        S_RDR   = 11'b000_0010_0000,
        S_PUSHL = 11'b000_0100_0000,
        S_PUSHR = 11'b000_1000_0000,
        S_PUSHN = 11'b001_0000_0000,
        S_RET   = 11'b010_0000_0000,
        S_OUT   = 11'b100_0000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = (r_state == S_OUT);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_CLEAR: begin
                if (i_status.clr_done) begin
                    n_state = S_IDLE;
                end else begin
                    o_cmd.clr_step = 1'b1;
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state = i_status.noop ? S_OUT : S_ROOT;
                end
            end
            S_ROOT: begin
                o_cmd.ld_root = 1'b1;
                n_state = S_VISIT;
            end
            S_VISIT: begin
                o_cmd.visit = 1'b1;
                n_state = (i_status.cls_none || i_status.cls_full) ? S_RET : S_RDL;
            end
            S_RDL: begin
                o_cmd.ld_left = 1'b1;
                n_state = S_RDR;
            end
            S_RDR: begin
                o_cmd.ld_right = 1'b1;
                n_state = S_PUSHL;
            end
            S_PUSHL: begin
                o_cmd.push_l = 1'b1;
                n_state = i_status.pend_zero ? S_VISIT : S_PUSHR;
            end
            S_PUSHR: begin
                o_cmd.push_r = 1'b1;
                n_state = S_PUSHN;
            end
            S_PUSHN: begin
                o_cmd.push_n = 1'b1;
                n_state = S_VISIT;
            end
            S_RET: begin
                if (i_status.stack_empty) begin
                    n_state = S_OUT;
                end else begin
                    o_cmd.ret_step = 1'b1;
                    n_state = i_status.phase_right ? S_RET : S_VISIT;
                end
            end
            S_OUT: begin
                if (i_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_CLEAR;
        endcase
        if (i_cfg_we) begin
            n_state = S_CLEAR;
            o_cmd   = '0;
        end
    end

endmodule

`default_nettype wire

### sv/razct_dp.sv
// Datapath: node memory, walk stack, lazy add push-down, combine and zero count.
// Depends on razct_pkg; driven by commands from razct_ctrl.
`default_nettype none

module razct_dp import razct_pkg::*; (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_cfg_we,
    input  wire logic [CNT_W-1:0]          i_cfg_data,
    input  wire logic                      i_req_type,
    input  wire logic [POS_W-1:0]          i_range_first,
    input  wire logic [POS_W-1:0]          i_range_last,
    input  wire logic signed [DELTA_W-1:0] i_delta,
    input  wire t_cmd                      i_cmd,
    output t_status                        o_status,
    output logic [CNT_W-1:0]               o_zero_count
);

    t_word mem [NODE_SLOTS];
    t_word r_rdata;
    logic [CNT_W-1:0] r_rspan;

    logic [CNT_W-1:0] r_npos;
    logic [CLR_W-1:0] r_clr;
    logic             r_type;
    logic [POS_W-1:0] r_first;
    logic [POS_W-1:0] r_last;
    logic signed [VAL_W-1:0] r_delta;
    logic [CNT_W-1:0] r_qsum;
    logic [SP_W-1:0]  r_sp;

    logic [ADDR_W-1:0] r_cur_addr;
    logic [POS_W-1:0]  r_cur_lo;
    logic [POS_W-1:0]  r_cur_hi;
    t_node             r_cur_val;
    t_node             r_ret;

    logic [ADDR_W-1:0] r_f_addr  [STACK_DEPTH];
    logic [ADDR_W-1:0] r_f_right [STACK_DEPTH];
    logic [POS_W-1:0]  r_f_lo    [STACK_DEPTH];
    logic [POS_W-1:0]  r_f_hi    [STACK_DEPTH];
    logic [POS_W-1:0]  r_f_md    [STACK_DEPTH];
    t_node             r_f_val   [STACK_DEPTH];
    t_node             r_f_lval  [STACK_DEPTH];
    t_node             r_f_rval  [STACK_DEPTH];
    logic              r_f_phase [STACK_DEPTH];

    logic [POS_W-1:0]  top_pos;
    logic              noop;
    logic [POS_W-1:0]  last_clip;
    logic [CNT_W-1:0]  cfg_clamped;
    logic [SP_W-1:0]   tidx;
    logic [POS_W-1:0]  cur_md;
    logic [ADDR_W-1:0] cur_right;
    logic              cls_none;
    logic              cls_full;
    t_node             rd_node;
    t_node             comb_val;
    t_node             push_l_val;
    t_node             push_r_val;
    t_node             cleared_val;

    logic              we;
    logic [ADDR_W-1:0] waddr;
    t_word             wdata;
    logic [ADDR_W-1:0] raddr;
    logic [CNT_W-1:0]  rspan;

    assign top_pos   = POS_W'(r_npos - CNT_W'(1));
    assign noop      = (i_range_first > i_range_last) || (i_range_first > top_pos);
    assign last_clip = (i_range_last > top_pos) ? top_pos : i_range_last;
    assign tidx      = r_sp - SP_W'(1);

    always_comb begin
        if (i_cfg_data == '0) begin
            cfg_clamped = CNT_W'(1);
        end else if (i_cfg_data > CNT_W'(MAX_POSITIONS)) begin
            cfg_clamped = CNT_W'(MAX_POSITIONS);
        end else begin
            cfg_clamped = i_cfg_data;
        end
    end

    assign cur_md    = r_cur_lo + ((r_cur_hi - r_cur_lo) >> 1);
    assign cur_right = r_cur_addr + {ADDR_W'(cur_md - r_cur_lo) + ADDR_W'(1)} * ADDR_W'(2);
    assign cls_none  = (r_first > r_cur_hi) || (r_last < r_cur_lo);
    assign cls_full  = (r_first <= r_cur_lo) && (r_last >= r_cur_hi);

    always_comb begin
        if (r_rdata.valid) begin
            rd_node = r_rdata.node;
        end else begin
            rd_node.mn   = '0;
            rd_node.cnt  = r_rspan;
            rd_node.pend = '0;
        end
    end

    always_comb begin
        comb_val.pend = '0;
        if (r_f_lval[tidx].mn < r_ret.mn) begin
            comb_val.mn  = r_f_lval[tidx].mn;
            comb_val.cnt = r_f_lval[tidx].cnt;
        end else if (r_f_lval[tidx].mn > r_ret.mn) begin
            comb_val.mn  = r_ret.mn;
            comb_val.cnt = r_ret.cnt;
        end else begin
            comb_val.mn  = r_ret.mn;
            comb_val.cnt = r_f_lval[tidx].cnt + r_ret.cnt;
        end
    end

    assign push_l_val       = apply_add(r_f_lval[tidx], r_f_val[tidx].pend);
    assign push_r_val       = apply_add(r_f_rval[tidx], r_f_val[tidx].pend);
    always_comb begin
        cleared_val      = r_f_val[tidx];
        cleared_val.pend = '0;
    end

    always_comb begin
        we    = 1'b0;
        waddr = '0;
        wdata = '0;
        raddr = '0;
        rspan = '0;
        if (i_cmd.clr_step) begin
            we    = 1'b1;
            waddr = r_clr[ADDR_W-1:0];
        end
        if (i_cmd.accept) begin
            rspan = r_npos;
        end
        if (i_cmd.visit && !cls_none && cls_full && r_type == REQ_ADD) begin
            we    = 1'b1;
            waddr = r_cur_addr;
            wdata = {1'b1, apply_add(r_cur_val, r_delta)};
        end
        if (i_cmd.visit && !cls_none && !cls_full) begin
            raddr = r_cur_addr + ADDR_W'(1);
            rspan = CNT_W'(cur_md - r_cur_lo) + CNT_W'(1);
        end
        if (i_cmd.ld_left) begin
            raddr = r_f_right[tidx];
            rspan = CNT_W'(r_f_hi[tidx] - r_f_md[tidx]);
        end
        if (i_cmd.push_l && r_f_val[tidx].pend != '0) begin
            we    = 1'b1;
            waddr = r_f_addr[tidx] + ADDR_W'(1);
            wdata = {1'b1, push_l_val};
        end
        if (i_cmd.push_r) begin
            we    = 1'b1;
            waddr = r_f_right[tidx];
            wdata = {1'b1, push_r_val};
        end
        if (i_cmd.push_n) begin
            we    = 1'b1;
            waddr = r_f_addr[tidx];
            wdata = {1'b1, cleared_val};
        end
        if (i_cmd.ret_step && r_f_phase[tidx] && r_type == REQ_ADD) begin
            we    = 1'b1;
            waddr = r_f_addr[tidx];
            wdata = {1'b1, comb_val};
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        r_rdata <= mem[raddr];
        r_rspan <= rspan;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_npos <= CNT_W'(MAX_POSITIONS);
            r_clr  <= '0;
            r_sp   <= '0;
            r_qsum <= '0;
        end else begin
            if (i_cfg_we) begin
                r_npos <= cfg_clamped;
                r_clr  <= '0;
            end else if (i_cmd.clr_step) begin
                r_clr <= r_clr + CLR_W'(1);
            end
            if (i_cmd.accept) begin
                r_qsum <= '0;
                r_sp   <= '0;
            end
            if (i_cmd.visit && !cls_none && cls_full && r_type == REQ_QUERY
                && r_cur_val.mn == '0) begin
                r_qsum <= r_qsum + r_cur_val.cnt;
            end
            if (i_cmd.visit && !cls_none && !cls_full) begin
                r_sp <= r_sp + SP_W'(1);
            end
            if (i_cmd.ret_step && r_f_phase[tidx]) begin
                r_sp <= tidx;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_type  <= i_req_type;
            r_first <= i_range_first;
            r_last  <= last_clip;
            r_delta <= {{(VAL_W-DELTA_W){i_delta[DELTA_W-1]}}, i_delta};
        end
        if (i_cmd.ld_root) begin
            r_cur_addr <= '0;
            r_cur_lo   <= '0;
            r_cur_hi   <= top_pos;
            r_cur_val  <= rd_node;
        end
        if (i_cmd.visit) begin
            if (cls_none) begin
                r_ret <= r_cur_val;
            end else if (cls_full) begin
                r_ret <= (r_type == REQ_ADD) ? apply_add(r_cur_val, r_delta) : r_cur_val;
            end else begin
                r_f_addr[r_sp]  <= r_cur_addr;
                r_f_right[r_sp] <= cur_right;
                r_f_lo[r_sp]    <= r_cur_lo;
                r_f_hi[r_sp]    <= r_cur_hi;
                r_f_md[r_sp]    <= cur_md;
                r_f_val[r_sp]   <= r_cur_val;
                r_f_phase[r_sp] <= 1'b0;
            end
        end
        if (i_cmd.ld_left) begin
            r_f_lval[tidx] <= rd_node;
        end
        if (i_cmd.ld_right) begin
            r_f_rval[tidx] <= rd_node;
        end
        if (i_cmd.push_l) begin
            if (r_f_val[tidx].pend != '0) begin
                r_f_lval[tidx] <= push_l_val;
            end else begin
                r_cur_addr <= r_f_addr[tidx] + ADDR_W'(1);
                r_cur_lo   <= r_f_lo[tidx];
                r_cur_hi   <= r_f_md[tidx];
                r_cur_val  <= r_f_lval[tidx];
            end
        end
        if (i_cmd.push_r) begin
            r_f_rval[tidx] <= push_r_val;
        end
        if (i_cmd.push_n) begin
            r_f_val[tidx] <= cleared_val;
            r_cur_addr    <= r_f_addr[tidx] + ADDR_W'(1);
            r_cur_lo      <= r_f_lo[tidx];
            r_cur_hi      <= r_f_md[tidx];
            r_cur_val     <= r_f_lval[tidx];
        end
        if (i_cmd.ret_step) begin
            if (!r_f_phase[tidx]) begin
                r_f_lval[tidx]  <= r_ret;
                r_f_phase[tidx] <= 1'b1;
                r_cur_addr      <= r_f_right[tidx];
                r_cur_lo        <= r_f_md[tidx] + POS_W'(1);
                r_cur_hi        <= r_f_hi[tidx];
                r_cur_val       <= r_f_rval[tidx];
            end else begin
                r_ret <= (r_type == REQ_ADD) ? comb_val : r_f_val[tidx];
            end
        end
    end

    assign o_status.noop        = noop;
    assign o_status.cls_none    = cls_none;
    assign o_status.cls_full    = cls_full;
    assign o_status.pend_zero   = (r_f_val[tidx].pend == '0);
    assign o_status.stack_empty = (r_sp == '0);
    assign o_status.phase_right = r_f_phase[tidx];
    assign o_status.clr_done    = r_clr[CLR_W-1];

    assign o_zero_count = r_qsum;

endmodule

`default_nettype wire

### sv/razct_checker.sv
// Port-level checker for the range add and zero count tree, with its bind to the top level.
// Depends on razct_pkg for field widths.
`default_nettype none

module razct_checker import razct_pkg::*; (
    input wire logic             i_clk,
    input wire logic             i_rst_n,
    input wire logic             i_valid,
    input wire logic             o_ready,
    input wire logic [POS_W-1:0] i_range_first,
    input wire logic [POS_W-1:0] i_range_last,
    input wire logic             o_valid,
    input wire logic             i_ready,
    input wire logic [CNT_W-1:0] o_zero_count
);

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_ready)
        else $error("Block not quiet after reset.");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready)
        else $error("Input taken while a result is pending.");

    a_reversed_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && (i_range_first > i_range_last)
        |=> o_valid && (o_zero_count == '0))
        else $error("Reversed range did not answer zero at once.");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_zero_count))
        else $error("Stalled result changed.");

endmodule

bind range_add_zero_count_tree_top razct_checker u_razct_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (i_valid),
    .o_ready       (o_ready),
    .i_range_first (i_range_first),
    .i_range_last  (i_range_last),
    .o_valid       (o_valid),
    .i_ready       (i_ready),
    .o_zero_count  (o_zero_count)
);

`default_nettype wire

### bench/range_add_zero_count_tree_top_tb.sv
// Self-checking bench for range_add_zero_count_tree_top: range adds and zero-count queries.
// Depends on razct_pkg and the top module; it predicts results with its own lazy segment tree.
`default_nettype none

module range_add_zero_count_tree_top_tb;
    import razct_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic                      kind;
        logic [POS_W-1:0]          first;
        logic [POS_W-1:0]          last;
        logic signed [DELTA_W-1:0] delta;
    } req_t;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_valid;
    logic                      o_ready;
    logic                      i_req_type;
    logic [POS_W-1:0]          i_range_first;
    logic [POS_W-1:0]          i_range_last;
    logic signed [DELTA_W-1:0] i_delta;
    logic                      o_valid;
    logic                      i_ready;
    logic [CNT_W-1:0]          o_zero_count;
    logic                      i_cfg_we;
    logic [CNT_W-1:0]          i_cfg_data;

    range_add_zero_count_tree_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_req_type(i_req_type), .i_range_first(i_range_first),
        .i_range_last(i_range_last), .i_delta(i_delta),
        .o_valid(o_valid), .i_ready(i_ready), .o_zero_count(o_zero_count),
        .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data)
    );

    logic signed [VAL_W-1:0] tree_min [NODE_SLOTS];
    logic [CNT_W-1:0]        tree_cnt [NODE_SLOTS];
    logic signed [VAL_W-1:0] tree_pend [NODE_SLOTS];
    int unsigned             span;

    req_t             pending_reqs [$];
    logic [CNT_W-1:0] expected_counts [$];
    int               mismatches;
    int               checked;
    int               queries_seen;
    bit               steady;
    int               sent;

    function automatic logic signed [VAL_W-1:0] clamp_sum(int a, int b);
        int s;
        s = a + b;
        if (s > 32767) s = 32767;
        if (s < -32768) s = -32768;
        return s[VAL_W-1:0];
    endfunction

    function automatic void build_tree(int unsigned nd, int unsigned lo, int unsigned hi);
        int unsigned md;
        if (nd >= NODE_SLOTS) return;
        tree_min[nd] = '0;
        tree_pend[nd] = '0;
        tree_cnt[nd] = CNT_W'(hi - lo + 1);
        if (lo == hi) return;
        md = lo + (hi - lo) / 2;
        build_tree(nd + 1, lo, md);
        build_tree(nd + 2 * (md - lo + 1), md + 1, hi);
    endfunction

    function automatic void bump_node(int unsigned nd, int d);
        if (nd >= NODE_SLOTS) return;
        tree_min[nd] = clamp_sum(tree_min[nd], d);
        tree_pend[nd] = clamp_sum(tree_pend[nd], d);
    endfunction

    function automatic void settle_pending(int unsigned nd, int unsigned rt);
        int p;
        p = tree_pend[nd];
        if (p == 0) return;
        bump_node(nd + 1, p);
        bump_node(rt, p);
        tree_pend[nd] = '0;
    endfunction

    function automatic void add_span(int unsigned nd, int unsigned lo, int unsigned hi,
                                     int unsigned f, int unsigned l, int d);
        int unsigned md, rt, lf;
        if (nd >= NODE_SLOTS) return;
        if (f > hi || l < lo) return;
        if (f <= lo && l >= hi) begin
            bump_node(nd, d);
            return;
        end
        md = lo + (hi - lo) / 2;
        rt = nd + 2 * (md - lo + 1);
        if (rt >= NODE_SLOTS) return;
        settle_pending(nd, rt);
        add_span(nd + 1, lo, md, f, l, d);
        add_span(rt, md + 1, hi, f, l, d);
        lf = nd + 1;
        if (tree_min[lf] < tree_min[rt]) begin
            tree_min[nd] = tree_min[lf];
            tree_cnt[nd] = tree_cnt[lf];
        end else if (tree_min[lf] > tree_min[rt]) begin
            tree_min[nd] = tree_min[rt];
            tree_cnt[nd] = tree_cnt[rt];
        end else begin
            tree_min[nd] = tree_min[lf];
            tree_cnt[nd] = tree_cnt[lf] + tree_cnt[rt];
        end
    endfunction

    function automatic int unsigned count_zeros(int unsigned nd, int unsigned lo,
                                                int unsigned hi, int unsigned f,
                                                int unsigned l);
        int unsigned md, rt;
        if (nd >= NODE_SLOTS) return 0;
        if (f > hi || l < lo) return 0;
        if (f <= lo && l >= hi) return (tree_min[nd] == 0) ? tree_cnt[nd] : 0;
        md = lo + (hi - lo) / 2;
        rt = nd + 2 * (md - lo + 1);
        if (rt >= NODE_SLOTS) return 0;
        settle_pending(nd, rt);
        return count_zeros(nd + 1, lo, md, f, l) + count_zeros(rt, md + 1, hi, f, l);
    endfunction

    function automatic void resize_tree(int unsigned raw);
        int unsigned v;
        v = raw & 'h7FF;
        if (v < 1) v = 1;
        if (v > MAX_POSITIONS) v = MAX_POSITIONS;
        span = v;
        build_tree(0, 0, span - 1);
    endfunction

    function automatic logic [CNT_W-1:0] predict_count(req_t r);
        int unsigned f, l, top, res;
        f = r.first;
        l = r.last;
        top = span - 1;
        res = 0;
        if (f <= l && f <= top) begin
            if (l > top) l = top;
            if (r.kind == REQ_ADD) add_span(0, 0, top, f, l, int'(r.delta));
            else res = count_zeros(0, 0, top, f, l);
        end
        return res[CNT_W-1:0];
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Driver: valid rises only when a transaction is queued and stays up until accepted.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            expected_counts.insert(expected_counts.size(),
                                   predict_count(pending_reqs.pop_front()));
            sent++;
            if (pending_reqs.size() > 0 && (steady || $urandom_range(99) >= 27)) begin
                i_valid       <= 1'b1;
                i_req_type    <= pending_reqs[0].kind;
                i_range_first <= pending_reqs[0].first;
                i_range_last  <= pending_reqs[0].last;
                i_delta       <= pending_reqs[0].delta;
            end else begin
                i_valid <= 1'b0;
            end
        end else if (!i_valid && pending_reqs.size() > 0
                     && (steady || $urandom_range(99) >= 27)) begin
            i_valid       <= 1'b1;
            i_req_type    <= pending_reqs[0].kind;
            i_range_first <= pending_reqs[0].first;
            i_range_last  <= pending_reqs[0].last;
            i_delta       <= pending_reqs[0].delta;
        end
    end

    // Monitor: compares each result transaction with the oldest prediction.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (expected_counts.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result transaction: zero_count=%0d", o_zero_count);
                end else begin
                    logic [CNT_W-1:0] want;
                    want = expected_counts.pop_front();
                    checked++;
                    if (o_zero_count !== want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("zero_count mismatch: expected %0d, actual %0d",
                                     want, o_zero_count);
                    end
                end
            end
            i_ready <= steady || ($urandom_range(99) >= 27);
        end
    end

    task automatic queue_req(logic kind, int f, int l, int d);
        req_t r;
        r.kind = kind;
        r.first = f[POS_W-1:0];
        r.last = l[POS_W-1:0];
        r.delta = d[DELTA_W-1:0];
        if (kind == REQ_QUERY) queries_seen++;
        pending_reqs.insert(pending_reqs.size(), r);
    endtask

    task automatic drain_all();
        while (pending_reqs.size() > 0 || expected_counts.size() > 0) @(posedge i_clk);
        repeat (600) @(posedge i_clk);
    endtask

    task automatic write_size(int unsigned v);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v[CNT_W-1:0];
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        resize_tree(v);
    endtask

    task automatic random_batch(int n, int unsigned sz);
        int a, b, lim;
        lim = (sz > MAX_POSITIONS) ? MAX_POSITIONS : sz;
        for (int i = 0; i < n; i++) begin
            a = $urandom_range(lim - 1);
            b = $urandom_range(lim - 1);
            if ($urandom_range(9) == 0) a = $urandom_range(1023);
            if ($urandom_range(9) == 0) b = $urandom_range(1023);
            if (a > b && $urandom_range(7) != 0) begin
                int t;
                t = a; a = b; b = t;
            end
            if ($urandom_range(1)) queue_req(REQ_QUERY, a, b, $urandom_range(255));
            else if ($urandom_range(19) == 0)
                queue_req(REQ_ADD, a, b, $urandom_range(255));
            else
                queue_req(REQ_ADD, a, b, $urandom_range(1) ? 1 : -1);
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_ready = 1'b0;
        i_req_type = 1'b0;
        i_range_first = '0;
        i_range_last = '0;
        i_delta = '0;
        i_cfg_we = 1'b0;
        i_cfg_data = '0;
        mismatches = 0;
        checked = 0;
        queries_seen = 0;
        sent = 0;
        steady = 1'b0;
        resize_tree(1024);
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        queue_req(REQ_QUERY, 0, 1023, 0);
        queue_req(REQ_ADD, 0, 1023, 127);
        queue_req(REQ_QUERY, 0, 1023, 0);
        queue_req(REQ_ADD, 0, 1023, -128);
        queue_req(REQ_ADD, 0, 1023, 1);
        queue_req(REQ_QUERY, 0, 1023, 0);
        queue_req(REQ_ADD, 5, 700, 3);
        queue_req(REQ_QUERY, 0, 1023, 0);
        queue_req(REQ_QUERY, 600, 4, 0);
        queue_req(REQ_ADD, 900, 3, 50);
        queue_req(REQ_QUERY, 1023, 1023, 0);
        queue_req(REQ_ADD, 5, 700, -3);
        queue_req(REQ_ADD, 10, 10, -1);
        queue_req(REQ_QUERY, 0, 20, 0);
        queue_req(REQ_ADD, 10, 10, 1);
        queue_req(REQ_QUERY, 0, 20, 0);
        for (int i = 0; i < 260; i++) queue_req(REQ_ADD, 0, 1, 127);
        queue_req(REQ_QUERY, 0, 1, 0);
        queue_req(REQ_ADD, 0, 1, -128);
        queue_req(REQ_QUERY, 0, 3, 0);
        drain_all();

        write_size(1);
        queue_req(REQ_QUERY, 0, 1023, 0);
        queue_req(REQ_QUERY, 1, 1023, 0);
        queue_req(REQ_ADD, 0, 0, 1);
        random_batch(40, 1);
        drain_all();

        write_size(0);
        random_batch(40, 2);
        drain_all();

        write_size(2047);
        random_batch(120, 1024);
        drain_all();

        write_size(37);
        steady = 1'b1;
        random_batch(80, 37);
        drain_all();
        steady = 1'b0;

        write_size(1024);
        random_batch(150, 1024);
        drain_all();

        write_size(700);
        random_batch(90, 700);
        drain_all();

        $display("Ran %0d transactions (%0d queries) over tree sizes 1 to 1024, %0d checked.",
                 sent, queries_seen, checked);
        if (mismatches == 0 && expected_counts.size() == 0) begin
            $display("range_add_zero_count_tree_top_tb OK");
        end else begin
            $display("Mismatches: %0d", mismatches);
            $display("range_add_zero_count_tree_top_tb NOT OK");
        end
        $finish;
    end

    initial begin
        #300ms;
        $display("range_add_zero_count_tree_top_tb NOT OK");
        $finish;
    end

endmodule

`default_nettype wire
